// File: hdl/pts_pkg.sv
package pts_pkg;

  localparam int TimerSlots     = 64;
  localparam int FiresPerUpdate = 16;

  localparam logic [47:0] TimeMax = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    CMD_ADD        = 3'd0,
    CMD_DELETE     = 3'd1,
    CMD_SET_PERIOD = 3'd2,
    CMD_SET_FIRE   = 3'd3,
    CMD_SET_MAX    = 3'd4,
    CMD_UPDATE     = 3'd5
  } cmd_code_t;

  typedef enum logic [2:0] {
    EV_DONE      = 3'd0,
    EV_REARMED   = 3'd1,
    EV_RELEASED  = 3'd2,
    EV_DELETED   = 3'd3,
    EV_NOT_FOUND = 3'd4,
    EV_FULL      = 3'd5,
    EV_BAD_ARG   = 3'd6
  } event_code_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] timer_id;
    logic [47:0] fire_ms;
    logic [31:0] period_ms;
    logic [15:0] max_fires;
    logic [47:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [31:0] event_id;
    logic [15:0] fires_so_far;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [31:0] id;
    logic [47:0] fire_ms;
    logic [31:0] period;
    logic [15:0] max_fires;
    logic [15:0] fire_count;
  } slot_t;

  function automatic logic bad_repeat(logic [31:0] period, logic [15:0] maxf);
    return (period == '0) && (maxf != 16'd1);
  endfunction

endpackage

// File: hdl/pts_slot_ram.sv
module pts_slot_ram #(
  parameter int Depth = pts_pkg::TimerSlots
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  pts_pkg::slot_t           wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output pts_pkg::slot_t           rdata
);
  import pts_pkg::*;

  slot_t mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/periodic_timer_scheduler.sv
// Operation: a command is scanned over all slots, one read per cycle, before its result is
//   valid. An update rescans per fired timer, each further result following once the one
//   before is taken.
// Flow: one command at a time. The slot memory's single read port sets the one-read-per-cycle
//   scan.
// Reset: synchronous rst clears the used bits and control; slot memory is not cleared.
module periodic_timer_scheduler #(
  parameter int TIMER_SLOTS      = pts_pkg::TimerSlots,
  parameter int FIRES_PER_UPDATE = pts_pkg::FiresPerUpdate
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  pts_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output pts_pkg::rsp_t out_data
);
  import pts_pkg::*;

  localparam int AW = $clog2(TIMER_SLOTS);
  localparam int NW = $clog2(FIRES_PER_UPDATE + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_ACT, S_WAIT, S_EMIT
  } state_t;

  state_t          state;
  req_t            req;
  logic [TIMER_SLOTS-1:0] used;
  logic [AW:0]     ptr;
  logic [AW-1:0]   rd_idx;
  logic            rd_vld;
  logic            rd_last;
  logic            hit;
  logic [AW-1:0]   hit_idx;
  slot_t           hit_slot;
  logic            free_fnd;
  logic [AW-1:0]   free_idx;
  logic [NW-1:0]   nfired;

  logic            we;
  logic [AW-1:0]   waddr;
  slot_t           wdata;
  logic [AW-1:0]   raddr;
  slot_t           rdata;

  logic            cand;
  logic            better;
  logic [48:0]     rearm;
  logic [15:0]     cnt_inc;

  assign raddr = ptr[AW-1:0];

  pts_slot_ram #(.Depth(TIMER_SLOTS)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign cand = rd_vld && used[rd_idx];
  always_comb begin
    if (req.cmd == CMD_UPDATE) begin
      better = cand && (!hit || rdata.fire_ms < hit_slot.fire_ms);
    end else begin
      better = cand && !hit && rdata.id == req.timer_id;
    end
  end
  assign cnt_inc = (hit_slot.fire_count == 16'hFFFF) ? hit_slot.fire_count
                                                      : hit_slot.fire_count + 16'd1;
  assign rearm = {1'b0, hit_slot.fire_ms} + {17'd0, hit_slot.period};

  always_ff @(posedge clk) begin
    we <= 1'b0;
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      out_valid <= 1'b0;
      rd_vld    <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req      <= in_data;
            nfired   <= '0;
            ptr      <= '0;
            hit      <= 1'b0;
            free_fnd <= 1'b0;
            rd_vld   <= 1'b0;
            if (in_data.cmd > CMD_UPDATE) begin
              out_data  <= '{EV_BAD_ARG, in_data.timer_id, 16'd0, 1'b1};
              out_valid <= 1'b1;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_vld  <= ptr < (AW+1)'(TIMER_SLOTS);
          rd_idx  <= ptr[AW-1:0];
          rd_last <= ptr == (AW+1)'(TIMER_SLOTS - 1);
          if (ptr < (AW+1)'(TIMER_SLOTS)) begin
            ptr <= ptr + 1'b1;
          end
          if (rd_vld && !used[rd_idx] && !free_fnd) begin
            free_fnd <= 1'b1;
            free_idx <= rd_idx;
          end
          if (better) begin
            hit      <= 1'b1;
            hit_idx  <= rd_idx;
            hit_slot <= rdata;
          end
          if (rd_vld && rd_last) begin
            rd_vld <= 1'b0;
            state  <= S_ACT;
          end
        end
        S_ACT: begin
          state     <= S_WAIT;
          out_valid <= 1'b1;
          out_data  <= '{EV_DONE, req.timer_id, hit ? hit_slot.fire_count : 16'd0, 1'b1};
          unique case (req.cmd)
            CMD_ADD: begin
              if (hit || bad_repeat(req.period_ms, req.max_fires)) begin
                out_data.event_kind <= EV_BAD_ARG;
                out_data.fires_so_far <= '0;
              end else if (!free_fnd) begin
                out_data.event_kind <= EV_FULL;
              end else begin
                we    <= 1'b1;
                waddr <= free_idx;
                wdata <= '{req.timer_id, req.fire_ms, req.period_ms, req.max_fires, 16'd0};
                used[free_idx] <= 1'b1;
              end
            end
            CMD_UPDATE: begin
              if (!hit || hit_slot.fire_ms > req.now_ms ||
                  nfired == NW'(FIRES_PER_UPDATE)) begin
                out_data <= '{EV_DONE, 32'd0, 16'd0, 1'b1};
              end else begin
                nfired <= nfired + 1'b1;
                we     <= 1'b1;
                waddr  <= hit_idx;
                wdata  <= hit_slot;
                wdata.fire_count <= cnt_inc;
                out_data.event_id     <= hit_slot.id;
                out_data.fires_so_far <= cnt_inc;
                out_data.last         <= 1'b0;
                if (hit_slot.max_fires == '0 || cnt_inc < hit_slot.max_fires) begin
                  wdata.fire_ms <= rearm[48] ? TimeMax : rearm[47:0];
                  out_data.event_kind <= EV_REARMED;
                end else begin
                  used[hit_idx] <= 1'b0;
                  out_data.event_kind <= EV_RELEASED;
                end
              end
            end
            default: begin
              waddr <= hit_idx;
              wdata <= hit_slot;
              if (!hit) begin
                out_data.event_kind <= EV_NOT_FOUND;
              end else if (req.cmd == CMD_DELETE) begin
                out_data.event_kind <= EV_DELETED;
                used[hit_idx] <= 1'b0;
              end else if (req.cmd == CMD_SET_PERIOD) begin
                if (bad_repeat(req.period_ms, hit_slot.max_fires)) begin
                  out_data.event_kind <= EV_BAD_ARG;
                end else begin
                  we <= 1'b1;
                  wdata.period <= req.period_ms;
                end
              end else if (req.cmd == CMD_SET_FIRE) begin
                we <= 1'b1;
                wdata.fire_ms <= req.fire_ms;
              end else begin
                if (bad_repeat(hit_slot.period, req.max_fires)) begin
                  out_data.event_kind <= EV_BAD_ARG;
                end else begin
                  we <= 1'b1;
                  wdata.max_fires <= req.max_fires;
                end
              end
            end
          endcase
        end
        S_WAIT: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid) begin
            if (out_data.last) begin
              state <= S_IDLE;
            end else begin
              ptr   <= '0;
              hit   <= 1'b0;
              state <= S_SCAN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
